>>> design/rpcde_pkg.sv
// ----------------------------------------------------------------------------
// rpcde_pkg
// Shared types, opcode constants and the cache hash for the pixel encoder.
// ----------------------------------------------------------------------------
package rpcde_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int CACHE_IDX_W   = 6;
  localparam int RUN_W         = 6;
  localparam int BYTES_MAX     = 5;
  localparam int CNT_W         = 3;

  // opcodes of the compressed stream
  localparam logic [7:0] OP_RGB   = 8'h3F;
  localparam logic [7:0] OP_INDEX = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_DIFF  = 8'hC0;

  // hash weights
  localparam logic [12:0] HASH_R = 13'd7;
  localparam logic [12:0] HASH_G = 13'd11;
  localparam logic [12:0] HASH_B = 13'd13;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic                   image_start;
    logic                   image_end;
    logic [CACHE_IDX_W-1:0] idx;
  } pix_item_t;

  typedef struct packed {
    logic [BYTES_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic [RUN_W-1:0]          run_nxt;
    logic                      cache_we;
  } enc_res_t;

  function automatic logic [CACHE_IDX_W-1:0] pixel_slot(
    input logic [7:0] r,
    input logic [7:0] g,
    input logic [7:0] b
  );
    logic [12:0] sum;
    sum = 13'(r) * HASH_R + 13'(g) * HASH_G + 13'(b) * HASH_B;
    return sum[CACHE_IDX_W-1:0];
  endfunction

endpackage

>>> design/rpcde_ifs.sv
// ----------------------------------------------------------------------------
// rpcde channel interfaces
// Valid/ready channels for input pixels and output code bytes.
// ----------------------------------------------------------------------------
interface rpcde_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       image_start;
  logic       image_end;

  modport source (output valid, red, green, blue, image_start, image_end, input ready);
  modport sink   (input valid, red, green, blue, image_start, image_end, output ready);
endinterface

interface rpcde_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       pixel_done;

  modport source (output valid, code_byte, pixel_done, input ready);
  modport sink   (input valid, code_byte, pixel_done, output ready);
endinterface

>>> design/rgb_pixel_run_cache_delta_encoder.sv
// ----------------------------------------------------------------------------
// rgb_pixel_run_cache_delta_encoder
// Pixel stream encoder with runs, a 64-entry color cache and delta codes.
//
//   channel   dir  payload                                   handshake
//   in_pixel  in   red, green, blue, image_start, image_end  valid/ready
//   out_code  out  code_byte, pixel_done                      valid/ready
//
// A pixel is registered with its cache read, coded in the next cycle and its
// bytes are loaded into the output buffer register, from which out_code
// offers them.
// Zero-byte pixels go at one per cycle, as do one-byte pixels while out_code
// is ready; a pixel giving more bytes holds the coder until the one-byte
// output channel has sent them (up to 5 for a run flush plus a literal).
// Synchronous reset clears control state and all cache valid bits at once.
// A stalled output holds the buffer and backs up to in_pixel.ready.
// ----------------------------------------------------------------------------
module rgb_pixel_run_cache_delta_encoder #(
  parameter int MAX_RUN = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  rpcde_pixel_if.sink        in_pixel,
  rpcde_code_if.source       out_code
);

  rpcde_pkg::pix_item_t        in_item;
  rpcde_pkg::pix_item_t        a_item_r;
  logic                        a_valid_r;
  rpcde_pkg::rgb_t             prev_r;
  logic [rpcde_pkg::RUN_W-1:0] run_r;
  rpcde_pkg::rgb_t             entry;
  rpcde_pkg::enc_res_t         res;
  logic                        can_load;
  logic                        consume;
  logic                        accept;

  always_comb begin
    in_item.red         = in_pixel.red;
    in_item.green       = in_pixel.green;
    in_item.blue        = in_pixel.blue;
    in_item.image_start = in_pixel.image_start;
    in_item.image_end   = in_pixel.image_end;
    in_item.idx         = rpcde_pkg::pixel_slot(in_pixel.red, in_pixel.green,
                                                in_pixel.blue);
  end

  // a pixel with no bytes leaves without waiting for the buffer
  assign consume        = a_valid_r && ((res.count == '0) || can_load);
  assign in_pixel.ready = !a_valid_r || consume;
  assign accept         = in_pixel.valid && in_pixel.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      prev_r    <= '0;
      run_r     <= '0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (consume) begin
        a_valid_r <= 1'b0;
      end
      if (consume) begin
        prev_r <= {a_item_r.red, a_item_r.green, a_item_r.blue};
        run_r  <= res.run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= in_item;
    end
  end

  rpcde_cache u_cache (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (in_item.idx),
    .wr_en   (consume && res.cache_we),
    .wr_idx  (a_item_r.idx),
    .wr_data ({a_item_r.red, a_item_r.green, a_item_r.blue}),
    .clear   (consume && a_item_r.image_start),
    .entry   (entry)
  );

  rpcde_encode #(
    .MAX_RUN (MAX_RUN)
  ) u_encode (
    .item  (a_item_r),
    .prev  (prev_r),
    .run   (run_r),
    .entry (entry),
    .res   (res)
  );

  rpcde_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume && (res.count != '0)),
    .load_bytes (res.bytes),
    .load_cnt   (res.count),
    .can_load   (can_load),
    .out_code   (out_code)
  );

endmodule

>>> design/rpcde_cache.sv
// ----------------------------------------------------------------------------
// rpcde_cache
// 64-entry color cache: registered read, per-entry valid bits cleared at
// image start, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module rpcde_cache (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [rpcde_pkg::CACHE_IDX_W-1:0] rd_idx,
  input  logic                             wr_en,
  input  logic [rpcde_pkg::CACHE_IDX_W-1:0] wr_idx,
  input  rpcde_pkg::rgb_t                  wr_data,
  input  logic                             clear,
  output rpcde_pkg::rgb_t                  entry
);

  rpcde_pkg::rgb_t mem [rpcde_pkg::CACHE_ENTRIES];

  logic [rpcde_pkg::CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  rpcde_pkg::rgb_t rd_data_r;
  rpcde_pkg::rgb_t fwd_data_r;
  logic            vld_r;
  logic            fwd_r;

  always_comb begin
    valid_nxt = clear ? '0 : valid_r;
    if (wr_en) begin
      valid_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_r   <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) begin
        vld_r <= valid_nxt[rd_idx];
        fwd_r <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_idx];
      fwd_data_r <= wr_data;
    end
  end

  // an entry not written since the last clear reads as black
  assign entry = fwd_r ? fwd_data_r : (vld_r ? rd_data_r : '0);

endmodule

>>> design/rpcde_encode.sv
// ----------------------------------------------------------------------------
// rpcde_encode
// Code selection for one pixel: run, cache hit, small delta, luma delta or
// literal, with the pending run flushed ahead of any other code.
// ----------------------------------------------------------------------------
module rpcde_encode #(
  parameter int MAX_RUN = 63
) (
  input  rpcde_pkg::pix_item_t        item,
  input  rpcde_pkg::rgb_t             prev,
  input  logic [rpcde_pkg::RUN_W-1:0] run,
  input  rpcde_pkg::rgb_t             entry,
  output rpcde_pkg::enc_res_t         res
);

  rpcde_pkg::rgb_t              pix, prev_eff, entry_eff;
  logic [rpcde_pkg::RUN_W-1:0]  run_eff, run_inc;
  logic [7:0]                   dr_u, dg_u, db_u, gr_u, br_u;
  logic signed [7:0]            dr, dg, db;
  logic signed [8:0]            gr, br;
  logic [7:0]                   dr2, dg2, db2, dr32, gr8, br8;
  logic                         small_ok, luma_ok;
  logic [3:0][7:0]              code;
  logic [rpcde_pkg::CNT_W-1:0]  code_cnt;

  always_comb begin
    pix       = {item.red, item.green, item.blue};
    // image start acts on a cleared cache, previous pixel and run
    prev_eff  = item.image_start ? '0 : prev;
    run_eff   = item.image_start ? '0 : run;
    entry_eff = item.image_start ? '0 : entry;
    run_inc   = run_eff + 1'b1;

    dr_u = item.red   - prev_eff[23:16];
    dg_u = item.green - prev_eff[15:8];
    db_u = item.blue  - prev_eff[7:0];
    gr_u = dg_u - dr_u;
    br_u = db_u - dr_u;
    dr   = signed'(dr_u);
    dg   = signed'(dg_u);
    db   = signed'(db_u);
    gr   = {dg[7], dg} - {dr[7], dr};
    br   = {db[7], db} - {dr[7], dr};

    dr2  = dr_u + 8'd2;
    dg2  = dg_u + 8'd2;
    db2  = db_u + 8'd2;
    dr32 = dr_u + 8'd32;
    gr8  = gr_u + 8'd8;
    br8  = br_u + 8'd8;

    small_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
            && (db >= -8'sd2) && (db <= 8'sd1);
    luma_ok  = (dr >= -8'sd32) && (dr <= 8'sd31) && (gr >= -9'sd8) && (gr <= 9'sd7)
            && (br >= -9'sd8) && (br <= 9'sd7);

    code     = '0;
    code_cnt = '0;
    if (entry_eff == pix) begin
      code[0]  = rpcde_pkg::OP_INDEX | 8'(item.idx);
      code_cnt = 3'd1;
    end else if (small_ok) begin
      code[0]  = rpcde_pkg::OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
      code_cnt = 3'd1;
    end else if (luma_ok) begin
      code[0]  = rpcde_pkg::OP_LUMA | {2'b00, dr32[5:0]};
      code[1]  = {gr8[3:0], br8[3:0]};
      code_cnt = 3'd2;
    end else begin
      code[0]  = rpcde_pkg::OP_RGB;
      code[1]  = item.red;
      code[2]  = item.green;
      code[3]  = item.blue;
      code_cnt = 3'd4;
    end

    res = '0;
    if (!item.image_start && pix == prev) begin
      if (item.image_end || run_inc >= rpcde_pkg::RUN_W'(MAX_RUN)) begin
        res.bytes[0] = 8'(run_inc - 1'b1);
        res.count    = 3'd1;
        res.run_nxt  = '0;
      end else begin
        res.run_nxt  = run_inc;
      end
    end else begin
      res.run_nxt  = '0;
      res.cache_we = (entry_eff != pix);
      if (run_eff != '0) begin
        res.bytes[0]   = 8'(run_eff - 1'b1);
        res.bytes[4:1] = code;
        res.count      = code_cnt + 3'd1;
      end else begin
        res.bytes[3:0] = code;
        res.count      = code_cnt;
      end
    end
  end

endmodule

>>> design/rpcde_obuf.sv
// ----------------------------------------------------------------------------
// rpcde_obuf
// Output byte buffer: holds the bytes of one pixel and sends them one per
// request, marking the last one.
// ----------------------------------------------------------------------------
module rpcde_obuf (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [rpcde_pkg::BYTES_MAX-1:0][7:0]  load_bytes,
  input  logic [rpcde_pkg::CNT_W-1:0]           load_cnt,
  output logic                                  can_load,
  rpcde_code_if.source                          out_code
);

  logic [rpcde_pkg::BYTES_MAX-1:0][7:0] buf_r;
  logic [rpcde_pkg::CNT_W-1:0]          cnt_r;
  logic                                 pop;

  assign pop      = out_code.valid && out_code.ready;
  assign can_load = (cnt_r == '0) || ((cnt_r == 3'd1) && out_code.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_bytes;
    end else if (pop) begin
      buf_r <= {8'h00, buf_r[rpcde_pkg::BYTES_MAX-1:1]};
    end
  end

  assign out_code.valid      = (cnt_r != '0);
  assign out_code.code_byte  = buf_r[0];
  assign out_code.pixel_done = (cnt_r == 3'd1);

endmodule
